// ----- hdl/afk_pkg.sv -----
// Package for the three-joint arm forward-position block.
// Holds the fixed-point formats, sine polynomial coefficients and register codes.
// No dependencies.
package afk_pkg;

  localparam int AngW   = 16;
  localparam int TrigW  = 16;
  localparam int LenW   = 24;
  localparam int PosW   = 32;
  localparam int OutW   = 27;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [14:0] Quarter = 15'd16384;
  localparam logic [31:0] CoefC1  = 32'd1686629713;
  localparam logic [31:0] CoefC3  = 32'd693598669;
  localparam logic [31:0] CoefC5  = 32'd85569306;
  localparam logic [31:0] CoefC7  = 32'd5026995;
  localparam logic [31:0] CoefC9  = 32'd172272;

  localparam int SinLat  = 6;
  localparam int LinkLat = 4;
  localparam int PipeLat = SinLat + 3 * LinkLat + 1;

  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  typedef logic signed [AngW-1:0]  angle_t;
  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [LenW-1:0]  len_t;
  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [OutW-1:0]  out_t;

  typedef struct packed {
    trig_t ca;
    trig_t sa;
    trig_t ct;
    trig_t st;
  } link_trig_t;

  typedef enum logic [2:0] {
    REG_TWIST_FIRST   = 3'd0,
    REG_TWIST_SECOND  = 3'd1,
    REG_LENGTH_FIRST  = 3'd2,
    REG_LENGTH_SECOND = 3'd3,
    REG_LENGTH_THIRD  = 3'd4,
    REG_OFFSET_FIRST  = 3'd5,
    REG_OFFSET_SECOND = 3'd6,
    REG_OFFSET_THIRD  = 3'd7
  } reg_idx_t;

endpackage

// ----- hdl/afk_if.sv -----
// Handshake interfaces for joint-angle beats and end-point beats.
// Depends on afk_pkg.
interface afk_in_if;
  logic                 valid;
  logic                 ready;
  afk_pkg::angle_t      joint_angle_one;
  afk_pkg::angle_t      joint_angle_two;
  afk_pkg::angle_t      joint_angle_three;

  modport source (output valid, joint_angle_one, joint_angle_two, joint_angle_three,
                  input ready);
  modport sink (input valid, joint_angle_one, joint_angle_two, joint_angle_three,
                output ready);
endinterface

interface afk_out_if;
  logic                 valid;
  logic                 ready;
  afk_pkg::out_t        pos_x;
  afk_pkg::out_t        pos_y;
  afk_pkg::out_t        pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ----- hdl/arm_forward_kinematics_3r.sv -----
// End-point position of a three-revolute-joint arm: ten sine lanes run side by side
// on the three joint angles and the two link twists, and three chained link stages merge them.
// One beat is taken every clock; the sine lanes, the three links and the output register
// follow one another, and a stalled output holds the whole pipeline.
module arm_forward_kinematics_3r (
  input  logic                        clk,
  input  logic                        rst_n,
  afk_in_if.sink                      in_bus,
  afk_out_if.source                   out_bus,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [afk_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [afk_pkg::DataW-1:0]   cfg_pwdata,
  output logic [afk_pkg::DataW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);
  import afk_pkg::*;

  angle_t twist1_r, twist2_r;
  len_t   len1_r, len2_r, len3_r, off1_r, off2_r, off3_r;
  reg_idx_t widx;
  logic   en;
  logic [PipeLat-1:0] valid_r;
  angle_t lane_ang [8];
  trig_t  lane_sin [8];
  link_trig_t tr3, tr2;
  pos_t   p0 [3], p3 [3], p2 [3], p1 [3];
  out_t   pos_x_r, pos_y_r, pos_z_r;

  function automatic out_t sat(input pos_t v);
    if (v > PosW'(OutMax)) begin
      return OutMax;
    end else if (v < PosW'(OutMin)) begin
      return OutMin;
    end
    return OutW'(v);
  endfunction

  assign widx = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twist1_r <= '0;
      twist2_r <= '0;
      len1_r   <= '0;
      len2_r   <= '0;
      len3_r   <= '0;
      off1_r   <= '0;
      off2_r   <= '0;
      off3_r   <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (widx)
        REG_TWIST_FIRST:   twist1_r <= cfg_pwdata[AngW-1:0];
        REG_TWIST_SECOND:  twist2_r <= cfg_pwdata[AngW-1:0];
        REG_LENGTH_FIRST:  len1_r   <= cfg_pwdata[LenW-1:0];
        REG_LENGTH_SECOND: len2_r   <= cfg_pwdata[LenW-1:0];
        REG_LENGTH_THIRD:  len3_r   <= cfg_pwdata[LenW-1:0];
        REG_OFFSET_FIRST:  off1_r   <= cfg_pwdata[LenW-1:0];
        REG_OFFSET_SECOND: off2_r   <= cfg_pwdata[LenW-1:0];
        REG_OFFSET_THIRD:  off3_r   <= cfg_pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_TWIST_FIRST:   cfg_prdata = DataW'({16'b0, twist1_r});
      REG_TWIST_SECOND:  cfg_prdata = DataW'({16'b0, twist2_r});
      REG_LENGTH_FIRST:  cfg_prdata = DataW'({8'b0, len1_r});
      REG_LENGTH_SECOND: cfg_prdata = DataW'({8'b0, len2_r});
      REG_LENGTH_THIRD:  cfg_prdata = DataW'({8'b0, len3_r});
      REG_OFFSET_FIRST:  cfg_prdata = DataW'({8'b0, off1_r});
      REG_OFFSET_SECOND: cfg_prdata = DataW'({8'b0, off2_r});
      REG_OFFSET_THIRD:  cfg_prdata = DataW'({8'b0, off3_r});
      default:           cfg_prdata = '0;
    endcase
  end

  assign en = !valid_r[PipeLat-1] || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[PipeLat-2:0], in_bus.valid};
    end
  end

  assign lane_ang[0] = in_bus.joint_angle_three;
  assign lane_ang[1] = in_bus.joint_angle_three + AngW'(Quarter);
  assign lane_ang[2] = in_bus.joint_angle_two;
  assign lane_ang[3] = in_bus.joint_angle_two + AngW'(Quarter);
  assign lane_ang[4] = twist2_r;
  assign lane_ang[5] = twist2_r + AngW'(Quarter);
  assign lane_ang[6] = in_bus.joint_angle_one;
  assign lane_ang[7] = in_bus.joint_angle_one + AngW'(Quarter);

  for (genvar i = 0; i < 8; i++) begin : g_lane
    afk_sin u_sin (
      .clk   (clk),
      .en    (en),
      .angle (lane_ang[i]),
      .sin_o (lane_sin[i])
    );
  end

  assign tr3 = '{ca: TrigW'(Quarter), sa: '0, ct: lane_sin[1], st: lane_sin[0]};
  assign tr2 = '{ca: lane_sin[5], sa: lane_sin[4], ct: lane_sin[3], st: lane_sin[2]};

  assign p0[0] = '0;
  assign p0[1] = '0;
  assign p0[2] = '0;

  afk_link #(.TrigDly(0)) u_link3 (
    .clk(clk), .en(en), .trig(tr3), .len_a(len3_r), .off_d(off3_r), .p_in(p0), .p_out(p3)
  );
  afk_link #(.TrigDly(LinkLat)) u_link2 (
    .clk(clk), .en(en), .trig(tr2), .len_a(len2_r), .off_d(off2_r), .p_in(p3), .p_out(p2)
  );

  link_trig_t tw1_trig;
  angle_t     tw1_ang [2];
  trig_t      tw1_sin [2];
  assign tw1_ang[0] = twist1_r;
  assign tw1_ang[1] = twist1_r + AngW'(Quarter);

  for (genvar j = 0; j < 2; j++) begin : g_tw1
    afk_sin u_sin (
      .clk   (clk),
      .en    (en),
      .angle (tw1_ang[j]),
      .sin_o (tw1_sin[j])
    );
  end

  assign tw1_trig = '{ca: tw1_sin[1], sa: tw1_sin[0], ct: lane_sin[7], st: lane_sin[6]};

  afk_link #(.TrigDly(2 * LinkLat)) u_link1 (
    .clk(clk), .en(en), .trig(tw1_trig), .len_a(len1_r), .off_d(off1_r), .p_in(p2),
    .p_out(p1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x_r <= sat(p1[0]);
      pos_y_r <= sat(p1[1]);
      pos_z_r <= sat(p1[2]);
    end
  end

  assign out_bus.valid = valid_r[PipeLat-1];
  assign out_bus.pos_x = pos_x_r;
  assign out_bus.pos_y = pos_y_r;
  assign out_bus.pos_z = pos_z_r;
endmodule

// ----- hdl/afk_sin.sv -----
// One sine lane: quadrant reduction, four Horner steps, final scale and round.
// Depends on afk_pkg.
module afk_sin (
  input  logic            clk,
  input  logic            en,
  input  afk_pkg::angle_t angle,
  output afk_pkg::trig_t  sin_o
);
  import afk_pkg::*;

  logic [14:0] r_nxt;
  logic [14:0] r_r   [5];
  logic        neg_r [5];
  logic [30:0] z2_r  [4];
  logic [31:0] p_r   [4];
  logic [31:0] coef  [4];
  logic [29:0] rsq;
  trig_t       sin_r;
  logic [46:0] fin_prod;
  logic [16:0] fin_s;

  assign coef[0] = CoefC7;
  assign coef[1] = CoefC5;
  assign coef[2] = CoefC3;
  assign coef[3] = CoefC1;

  always_comb begin
    if (angle[14]) begin
      r_nxt = Quarter - {1'b0, angle[13:0]};
    end else begin
      r_nxt = {1'b0, angle[13:0]};
    end
  end

  assign rsq = 30'(r_nxt) * 30'(r_nxt);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= r_nxt;
      neg_r[0] <= angle[15];
      z2_r[0]  <= {rsq[28:0], 2'b00};
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_horner
    logic [62:0] prod;
    logic [31:0] p_in;
    assign p_in = (k == 0) ? CoefC9 : p_r[(k == 0) ? 0 : k - 1];
    assign prod = 63'(p_in) * 63'(z2_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k]     <= coef[k] - prod[61:30];
        r_r[k+1]   <= r_r[k];
        neg_r[k+1] <= neg_r[k];
        if (k < 3) begin
          z2_r[(k < 3) ? k + 1 : 0] <= z2_r[k];
        end
      end
    end
  end

  assign fin_prod = 47'(p_r[3]) * 47'(r_r[4]) + 47'(33'h20000000);
  assign fin_s = (fin_prod[46:30] > 17'(Quarter)) ? 17'(Quarter) : fin_prod[46:30];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= neg_r[4] ? -trig_t'(fin_s) : trig_t'(fin_s);
    end
  end

  assign sin_o = sin_r;
endmodule

// ----- hdl/afk_link.sv -----
// One Denavit-Hartenberg link: p <- Rz(theta) Tz(d) Tx(a) Rx(alpha) p, four stages.
// Depends on afk_pkg.
module afk_link #(
  parameter int TrigDly = 0
) (
  input  logic                clk,
  input  logic                en,
  input  afk_pkg::link_trig_t trig,
  input  afk_pkg::len_t       len_a,
  input  afk_pkg::len_t       off_d,
  input  afk_pkg::pos_t       p_in  [3],
  output afk_pkg::pos_t       p_out [3]
);
  import afk_pkg::*;

  link_trig_t tr;
  logic signed [47:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [47:0] n1_r, n2_r, n3_r, n4_r;
  pos_t xa_r, xa2_r, u_r, p2_r, p2b_r;
  trig_t ct_r, st_r, ct2_r, st2_r;
  pos_t out_r [3];
  logic signed [48:0] su, sw, s0, s1;

  if (TrigDly > 0) begin : g_dly
    link_trig_t dly_r [TrigDly];
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[0] <= trig;
        for (int i = 1; i < TrigDly; i++) begin
          dly_r[i] <= dly_r[i-1];
        end
      end
    end
    assign tr = dly_r[TrigDly-1];
  end else begin : g_nodly
    assign tr = trig;
  end

  assign su = 49'(m1_r) - 49'(m2_r) + 49'sd8192;
  assign sw = 49'(m3_r) + 49'(m4_r) + 49'sd8192;
  assign s0 = 49'(n1_r) - 49'(n2_r) + 49'sd8192;
  assign s1 = 49'(n3_r) + 49'(n4_r) + 49'sd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= 48'(tr.ca) * 48'(p_in[1]);
      m2_r   <= 48'(tr.sa) * 48'(p_in[2]);
      m3_r   <= 48'(tr.sa) * 48'(p_in[1]);
      m4_r   <= 48'(tr.ca) * 48'(p_in[2]);
      xa_r   <= p_in[0] + PosW'(len_a);
      ct_r   <= tr.ct;
      st_r   <= tr.st;
      u_r    <= PosW'(su >>> 14);
      p2_r   <= PosW'(sw >>> 14) + PosW'(off_d);
      xa2_r  <= xa_r;
      ct2_r  <= ct_r;
      st2_r  <= st_r;
      n1_r   <= 48'(ct2_r) * 48'(xa2_r);
      n2_r   <= 48'(st2_r) * 48'(u_r);
      n3_r   <= 48'(st2_r) * 48'(xa2_r);
      n4_r   <= 48'(ct2_r) * 48'(u_r);
      p2b_r  <= p2_r;
      out_r[0] <= PosW'(s0 >>> 14);
      out_r[1] <= PosW'(s1 >>> 14);
      out_r[2] <= p2b_r;
    end
  end

  assign p_out = out_r;
endmodule

// ----- hdl/afk_check.sv -----
// Port-level checks for the arm forward-position block, bound to its top level.
// Depends on afk_pkg and arm_forward_kinematics_3r.
module afk_check (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input afk_pkg::out_t   pos_x
);
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output drain");
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped");
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pos_x))
    else $error("stalled result changed");
endmodule

bind arm_forward_kinematics_3r afk_check u_afk_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .pos_x     (out_bus.pos_x)
);

// ----- test/afk_tb_if.sv -----
// Testbench-side notes: the block's own interfaces (hdl/afk_if.sv) carry the beats.
// This file holds the scoreboard class that predicts end points. Depends on afk_pkg.
`timescale 1ns / 100ps

package afk_tb_pkg;
  import afk_pkg::*;

  typedef struct packed {
    logic [15:0] j1;
    logic [15:0] j2;
    logic [15:0] j3;
  } joints_t;

  typedef struct packed {
    logic [26:0] x;
    logic [26:0] y;
    logic [26:0] z;
  } point_t;

  class end_point_board;
    logic [15:0] twist [2];
    logic [23:0] link_len [3];
    logic [23:0] link_off [3];
    point_t pending [$];
    int errors;

    function new();
      errors = 0;
      foreach (twist[i]) twist[i] = '0;
      foreach (link_len[i]) begin
        link_len[i] = '0;
        link_off[i] = '0;
      end
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_TWIST_FIRST:   twist[0] = val[15:0];
        REG_TWIST_SECOND:  twist[1] = val[15:0];
        REG_LENGTH_FIRST:  link_len[0] = val[23:0];
        REG_LENGTH_SECOND: link_len[1] = val[23:0];
        REG_LENGTH_THIRD:  link_len[2] = val[23:0];
        REG_OFFSET_FIRST:  link_off[0] = val[23:0];
        REG_OFFSET_SECOND: link_off[1] = val[23:0];
        REG_OFFSET_THIRD:  link_off[2] = val[23:0];
        default: ;
      endcase
    endfunction

    function longint quarter_sine(longint unsigned r);
      longint unsigned z2, p, s;
      z2 = (r * r) << 2;
      p = 64'd172272;
      p = 64'd5026995 - ((p * z2) >> 30);
      p = 64'd85569306 - ((p * z2) >> 30);
      p = 64'd693598669 - ((p * z2) >> 30);
      p = 64'd1686629713 - ((p * z2) >> 30);
      s = (p * r + (64'd1 << 29)) >> 30;
      if (s > 64'd16384) s = 64'd16384;
      return longint'(s);
    endfunction

    function longint ang_sin(logic [15:0] a);
      logic [1:0] q;
      longint unsigned r;
      longint s;
      q = a[15:14];
      r = a[13:0];
      if (q[0]) r = 16384 - r;
      s = quarter_sine(r);
      return q[1] ? -s : s;
    endfunction

    function longint ang_cos(logic [15:0] a);
      return ang_sin(a + 16'd16384);
    endfunction

    function longint round_q14(longint v);
      if (v >= 0) return (v + 8192) >>> 14;
      return -((-v + 8191) >>> 14);
    endfunction

    function void apply_link(ref longint p[3], input logic [15:0] tw, input logic [15:0] th,
                             input longint a, input longint d);
      longint ca, sa, ct, st, u, w, xa;
      ca = ang_cos(tw);
      sa = ang_sin(tw);
      ct = ang_cos(th);
      st = ang_sin(th);
      u = round_q14(ca * p[1] - sa * p[2]);
      w = round_q14(sa * p[1] + ca * p[2]);
      xa = p[0] + a;
      p[0] = round_q14(ct * xa - st * u);
      p[1] = round_q14(st * xa + ct * u);
      p[2] = w + d;
    endfunction

    function logic [26:0] clamp27(longint v);
      if (v > 67108863) v = 67108863;
      if (v < -67108864) v = -67108864;
      return v[26:0];
    endfunction

    function void note_joints(joints_t j);
      longint p[3];
      point_t e;
      p[0] = 0; p[1] = 0; p[2] = 0;
      apply_link(p, 16'd0, j.j3, longint'($signed(link_len[2])),
                 longint'($signed(link_off[2])));
      apply_link(p, twist[1], j.j2, longint'($signed(link_len[1])),
                 longint'($signed(link_off[1])));
      apply_link(p, twist[0], j.j1, longint'($signed(link_len[0])),
                 longint'($signed(link_off[0])));
      e.x = clamp27(p[0]);
      e.y = clamp27(p[1]);
      e.z = clamp27(p[2]);
      pending.push_back(e);
    endfunction

    function void check_point(point_t got);
      point_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat x=%h y=%h z=%h", $time, got.x, got.y, got.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.x !== got.x) begin
        $display("%0t: pos_x exp %h got %h", $time, e.x, got.x);
        errors++;
      end
      if (e.y !== got.y) begin
        $display("%0t: pos_y exp %h got %h", $time, e.y, got.y);
        errors++;
      end
      if (e.z !== got.z) begin
        $display("%0t: pos_z exp %h got %h", $time, e.z, got.z);
        errors++;
      end
    endfunction
  endclass
endpackage

// ----- test/tb.sv -----
// Top of the forward-position testbench: drives joint beats and APB writes,
// stalls the result side, and checks every end point. Depends on afk_pkg, afk_tb_pkg.
`timescale 1ns / 100ps

module tb;
  import afk_pkg::*;
  import afk_tb_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [DataW-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;
  afk_in_if  in_bus ();
  afk_out_if out_bus ();

  end_point_board board;
  bit sending_done;
  bit hold_off;
  int idle_cycles;

  arm_forward_kinematics_3r u_dut (
    .clk, .rst_n, .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    in_bus.valid = 0;
    in_bus.joint_angle_one = '0;
    in_bus.joint_angle_two = '0;
    in_bus.joint_angle_three = '0;
    out_bus.ready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
    cfg_paddr = '0; cfg_pwdata = '0;
    board = new();
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= AddrW'(idx) << 2; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    board.set_reg(idx, val);
  endtask

  task automatic send_joints(joints_t j, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_bus.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1;
    in_bus.joint_angle_one <= j.j1;
    in_bus.joint_angle_two <= j.j2;
    in_bus.joint_angle_three <= j.j3;
    do @(posedge clk); while (!in_bus.ready);
    board.note_joints(j);
  endtask

  // keep valid high across back-to-back beats by skipping the drop when next gap is zero
  task automatic send_burst(joints_t js [$], bit no_gap);
    foreach (js[i]) begin
      send_joints(js[i], no_gap);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PipeLat + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3)) << 14;
      1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 4))
      0: return 32'h7FFFFF;
      1: return 32'h800000;
      2: return 32'($urandom_range(0, 8191)) - 32'd4096;
      default: return 32'($urandom) & 32'hFFFFFF;
    endcase
  endfunction

  task automatic random_config(bit extreme);
    write_reg(REG_TWIST_FIRST, extreme ? 32'h8000 : 32'(rand_angle()));
    write_reg(REG_TWIST_SECOND, extreme ? 32'h7FFF : 32'(rand_angle()));
    write_reg(REG_LENGTH_FIRST, extreme ? 32'h7FFFFF : rand_len());
    write_reg(REG_LENGTH_SECOND, extreme ? 32'h7FFFFF : rand_len());
    write_reg(REG_LENGTH_THIRD, extreme ? 32'h7FFFFF : rand_len());
    write_reg(REG_OFFSET_FIRST, extreme ? 32'h800000 : rand_len());
    write_reg(REG_OFFSET_SECOND, extreme ? 32'h800000 : rand_len());
    write_reg(REG_OFFSET_THIRD, extreme ? 32'h800000 : rand_len());
  endtask

  initial begin
    joints_t j;
    logic [15:0] corner [6];
    corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'hFFFF};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset config: every point is the origin
    j = '{16'h1234, 16'h8000, 16'hFFFF};
    send_joints(j, 0);
    drain();
    write_reg(REG_TWIST_FIRST, 32'h4000);
    write_reg(REG_TWIST_SECOND, 32'hC000);
    write_reg(REG_LENGTH_FIRST, 32'h001000);
    write_reg(REG_LENGTH_SECOND, 32'h002000);
    write_reg(REG_LENGTH_THIRD, 32'h003000);
    write_reg(REG_OFFSET_FIRST, 32'h000800);
    write_reg(REG_OFFSET_SECOND, 32'hFFF800);
    write_reg(REG_OFFSET_THIRD, 32'h000400);
    for (int i = 0; i < 6; i++) begin
      j = '{corner[i], corner[(i + 1) % 6], corner[(i + 3) % 6]};
      send_joints(j, 0);
    end
    drain();
    random_config(1);
    for (int i = 0; i < 12; i++) begin
      j = '{corner[i % 6], corner[(i / 2) % 6], corner[(i * 5) % 6]};
      send_joints(j, 0);
    end
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      random_config(phase == 3);
      if (phase == 1) hold_off = 1;
      for (int i = 0; i < 215; i++) begin
        j = '{rand_angle(), rand_angle(), rand_angle()};
        send_joints(j, (phase == 2) || ($urandom_range(0, 3) == 0));
      end
      drain();
    end
    sending_done = 1;
  end

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_bus.ready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_bus.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    point_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.x = out_bus.pos_x;
      got.y = out_bus.pos_y;
      got.z = out_bus.pos_z;
      board.check_point(got);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (sending_done) begin
        if (board.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("status: fail");
        $finish;
      end
    end
  end
endmodule

// ----- arm_forward_kinematics_3r.f -----
hdl/afk_pkg.sv
hdl/afk_if.sv
hdl/afk_sin.sv
hdl/afk_link.sv
hdl/arm_forward_kinematics_3r.sv
hdl/afk_check.sv
test/afk_tb_if.sv
test/tb.sv
